// ===== sv/chunked_z2_column_reduction_macros.svh =====
// Assertion macros shared by the checker of the column reduction block.
// No dependencies; the checker file includes this header by its bare name.
`ifndef CHUNKED_Z2_COLUMN_REDUCTION_MACROS_SVH
`define CHUNKED_Z2_COLUMN_REDUCTION_MACROS_SVH

// Checked at every rising edge outside of reset.
`define CZR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked at every rising edge, reset included.
`define CZR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/czr_pkg.sv =====
// Shared constants, codes and controller/datapath interface types of the
// column reduction block. No dependencies.
package czr_pkg;

   localparam int ROW_COUNT   = 1024;
   localparam int ROW_W       = $clog2(ROW_COUNT);
   localparam int WORD_BITS   = 64;
   localparam int BIT_W       = $clog2(WORD_BITS);
   localparam int WORDS       = ROW_COUNT / WORD_BITS;
   localparam int WORD_W      = $clog2(WORDS);
   localparam int MAX_CHUNK   = 256;
   localparam int SLOT_W      = $clog2(MAX_CHUNK);
   localparam int POS_W       = SLOT_W + 1;
   localparam int MAX_COLUMNS = 65536;
   localparam int COUNT_W     = $clog2(MAX_COLUMNS) + 1;
   localparam int STORE_W     = SLOT_W + WORD_W;

   localparam int OP_W      = 2;
   localparam int BIRTH_W   = 16;
   localparam int DEATH_W   = 11;
   localparam int ADDS_W    = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 9;

   typedef logic [OP_W-1:0] op_type;
   localparam op_type OP_ADD = 2'd0;
   localparam op_type OP_END = 2'd1;
   localparam op_type OP_NEW = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_CHUNK_COLUMNS      = 1'd0;
   localparam csr_idx_type CSR_INDEPENDENT_CHUNKS = 1'd1;

   localparam logic [CSR_W-1:0] CHUNK_COLUMNS_RESET = 9'd256;

   // Per-row record: owning slot, local ownership and global claim.
   typedef struct packed {
      logic [SLOT_W-1:0] owner;
      logic              valid;
      logic              claimed;
   } row_info_type;

   // Per-slot record of the pivot claimed in the current chunk.
   typedef struct packed {
      logic             has;
      logic [ROW_W-1:0] row;
   } pivot_type;

   typedef struct packed {
      logic clr_start;
      logic clr_row;
      logic add_entry;
      logic col_start;
      logic ovf_start;
      logic find_step;
      logic nopiv;
      logic ri_rd;
      logic add_start;
      logic st_rd;
      logic st_xor;
      logic claim;
      logic skip;
      logic wb;
      logic rsp_load;
      logic sw_start;
      logic sw_piv_rd;
      logic sw_ri_rd;
      logic sw_wr;
      logic sw_next;
      logic sw_done;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic word_nz;
      logic word_zero;
      logic word_last;
      logic ri_valid;
      logic ri_claimed;
      logic indep;
      logic full;
      logic chunk_due;
      logic sw_last;
      logic piv_has;
      logic rsp_busy;
      logic ovf;
   } status_type;

endpackage

// ===== sv/chunked_z2_column_reduction.sv =====
// Top level of the chunked GF(2) column reduction block.
// Depends on czr_pkg, czr_ctrl and czr_dpath.
//
// The block takes a boundary matrix one nonzero entry per transfer and
// reduces each column over GF(2) when its end arrives. A column end scans
// the working column from its top word down, one 64-bit word per cycle, to
// find the pivot, then looks up the owner of that row in the row table.
// Each column addition reads and XORs the owner's stored column word by
// word, each word first read from the store and then XORed in, followed by
// a fresh pivot scan. The reduced column is then written to the column
// store and the result transfer is offered, unless chunks are not
// independent and its pivot row was already claimed by an earlier chunk.
// When a chunk closes, every slot of that chunk is visited to promote its
// pivot: its pivot record is read and, for a slot with a pivot, the row
// entry is read and written back.
// After reset and after a new-matrix transfer the row table is cleared one
// row per cycle while no input transfer is taken; configuration writes are
// taken at all times. A finished result waits in its output register, so
// the block returns to taking entries while the result is still stalled.
module chunked_z2_column_reduction (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [czr_pkg::OP_W-1:0]            req_operation,
   input  logic [czr_pkg::ROW_W-1:0]           req_row_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [czr_pkg::BIRTH_W-1:0]         rsp_column_number,
   output logic signed [czr_pkg::DEATH_W-1:0]  rsp_pivot_row,
   output logic [czr_pkg::ADDS_W-1:0]          rsp_column_additions,
   output logic                                rsp_overflow,
   input  logic                                csr_write_enable,
   input  logic [czr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [czr_pkg::CSR_W-1:0]           csr_write_data
);
   import czr_pkg::*;

   // Commands flow from the controller to the datapath, status flows back.
   cmd_type    cmd;
   status_type status;

   czr_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .status        (status),
      .cmd           (cmd)
   );

   czr_dpath u_dpath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_row_index        (req_row_index),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_column_number    (rsp_column_number),
      .rsp_pivot_row        (rsp_pivot_row),
      .rsp_column_additions (rsp_column_additions),
      .rsp_overflow         (rsp_overflow)
   );

endmodule

// ===== sv/czr_dpath.sv =====
// Datapath of the column reduction block: working column, column store,
// row and pivot tables, counters and the result register. Uses czr_pkg.
module czr_dpath (
   input  logic                            clock,
   input  logic                            reset,
   input  czr_pkg::cmd_type                cmd,
   output czr_pkg::status_type             status,
   input  logic [czr_pkg::ROW_W-1:0]       req_row_index,
   input  logic                            csr_write_enable,
   input  logic [czr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [czr_pkg::CSR_W-1:0]       csr_write_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [czr_pkg::BIRTH_W-1:0]     rsp_column_number,
   output logic signed [czr_pkg::DEATH_W-1:0] rsp_pivot_row,
   output logic [czr_pkg::ADDS_W-1:0]      rsp_column_additions,
   output logic                            rsp_overflow
);
   import czr_pkg::*;

   logic [WORD_BITS-1:0] wc_ff [WORDS];
   logic [WORD_BITS-1:0] wc_in [WORDS];
   logic [WORD_BITS-1:0] store_mem [1 << STORE_W];
   logic [WORD_BITS-1:0] store_q_ff;
   row_info_type         ri_mem [ROW_COUNT];
   row_info_type         ri_q_ff;
   pivot_type            piv_mem [MAX_CHUNK];
   pivot_type            piv_q_ff;

   logic [WORD_W-1:0]  word_ff, word_in;
   logic [ROW_W-1:0]   clr_ff, clr_in;
   logic [SLOT_W-1:0]  sw_ff, sw_in;
   logic [DEATH_W-1:0] p_ff, p_in;
   logic [SLOT_W-1:0]  src_ff, src_in;
   logic [ADDS_W-1:0]  adds_ff, adds_in;
   logic               emit_ff, emit_in;
   logic               ovf_ff, ovf_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [CSR_W-1:0]   chunk_cols_ff, chunk_cols_in;
   logic               indep_ff, indep_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BIRTH_W-1:0] birth_ff, birth_in;
   logic [DEATH_W-1:0] death_ff, death_in;
   logic [ADDS_W-1:0]  radds_ff, radds_in;
   logic               rovf_ff, rovf_in;

   logic [WORD_BITS-1:0] word_val;
   logic [BIT_W-1:0]     penc;
   logic [POS_W-1:0]     limit;
   logic [SLOT_W-1:0]    slot;

   logic                 ri_we;
   logic [ROW_W-1:0]     ri_waddr;
   row_info_type         ri_wdata;
   logic                 ri_re;
   logic [ROW_W-1:0]     ri_raddr;

   assign word_val = wc_ff[word_ff];
   assign slot     = pos_ff[SLOT_W-1:0];

   // Highest set bit of the word under scan.
   always_comb begin
      penc = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (word_val[i]) begin
            penc = BIT_W'(i);
         end
      end
   end

   always_comb begin
      if (chunk_cols_ff == '0) begin
         limit = POS_W'(1);
      end else if (POS_W'(chunk_cols_ff) > POS_W'(MAX_CHUNK)) begin
         limit = POS_W'(MAX_CHUNK);
      end else begin
         limit = POS_W'(chunk_cols_ff);
      end
   end

   always_comb begin
      status.clr_last   = (clr_ff == ROW_W'(ROW_COUNT - 1));
      status.word_nz    = (word_val != '0);
      status.word_zero  = (word_ff == '0);
      status.word_last  = (word_ff == WORD_W'(WORDS - 1));
      status.ri_valid   = ri_q_ff.valid;
      status.ri_claimed = ri_q_ff.claimed;
      status.indep      = indep_ff;
      status.full       = (count_ff >= COUNT_W'(MAX_COLUMNS));
      status.chunk_due  = (pos_ff >= limit);
      status.sw_last    = ((POS_W'(sw_ff) + POS_W'(1)) >= pos_ff);
      status.piv_has    = piv_q_ff.has;
      status.rsp_busy   = emit_ff && rsp_valid_ff && rsp_stall;
      status.ovf        = ovf_ff;
   end

   // Row table port selection.
   always_comb begin
      ri_we    = 1'b0;
      ri_waddr = p_ff[ROW_W-1:0];
      ri_wdata = '{owner: slot, valid: 1'b1, claimed: ri_q_ff.claimed};
      if (cmd.clr_row) begin
         ri_we    = 1'b1;
         ri_waddr = clr_ff;
         ri_wdata = '0;
      end else if (cmd.claim) begin
         ri_we = 1'b1;
      end else if (cmd.sw_wr) begin
         ri_we    = 1'b1;
         ri_waddr = piv_q_ff.row;
         ri_wdata = '{owner: ri_q_ff.owner, valid: 1'b0,
                      claimed: ri_q_ff.claimed | ~indep_ff};
      end
      ri_re    = cmd.ri_rd | cmd.sw_ri_rd;
      ri_raddr = cmd.sw_ri_rd ? piv_q_ff.row : p_ff[ROW_W-1:0];
   end

   always_comb begin
      wc_in         = wc_ff;
      word_in       = word_ff;
      clr_in        = clr_ff;
      sw_in         = sw_ff;
      p_in          = p_ff;
      src_in        = src_ff;
      adds_in       = adds_ff;
      emit_in       = emit_ff;
      ovf_in        = ovf_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      chunk_cols_in = chunk_cols_ff;
      indep_in      = indep_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      birth_in      = birth_ff;
      death_in      = death_ff;
      radds_in      = radds_ff;
      rovf_in       = rovf_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_CHUNK_COLUMNS:      chunk_cols_in = csr_write_data;
            CSR_INDEPENDENT_CHUNKS: indep_in      = csr_write_data[0];
            default: ;
         endcase
      end

      if (cmd.clr_start) begin
         for (int w = 0; w < WORDS; w++) begin
            wc_in[w] = '0;
         end
         clr_in   = '0;
         count_in = '0;
         pos_in   = '0;
      end
      if (cmd.clr_row) begin
         clr_in = clr_ff + ROW_W'(1);
      end
      if (cmd.add_entry) begin
         wc_in[req_row_index[ROW_W-1:BIT_W]][req_row_index[BIT_W-1:0]] = 1'b1;
      end
      if (cmd.col_start) begin
         word_in = WORD_W'(WORDS - 1);
         adds_in = '0;
         emit_in = 1'b1;
         ovf_in  = 1'b0;
      end
      if (cmd.ovf_start) begin
         for (int w = 0; w < WORDS; w++) begin
            wc_in[w] = '0;
         end
         emit_in = 1'b1;
         ovf_in  = 1'b1;
      end
      if (cmd.find_step) begin
         if (word_val != '0) begin
            p_in = {1'b0, word_ff, penc};
         end else if (word_ff == '0) begin
            p_in = '1;
         end else begin
            word_in = word_ff - WORD_W'(1);
         end
      end
      if (cmd.add_start) begin
         src_in  = ri_q_ff.owner;
         word_in = '0;
         if (adds_ff != '1) begin
            adds_in = adds_ff + ADDS_W'(1);
         end
      end
      if (cmd.st_xor) begin
         wc_in[word_ff] = wc_ff[word_ff] ^ store_q_ff;
         // The top word stays selected so the next scan starts there.
         if (word_ff != WORD_W'(WORDS - 1)) begin
            word_in = word_ff + WORD_W'(1);
         end
      end
      if (cmd.claim || cmd.skip || cmd.nopiv) begin
         word_in = '0;
      end
      if (cmd.skip) begin
         emit_in = 1'b0;
      end
      if (cmd.wb) begin
         wc_in[word_ff] = '0;
         word_in        = word_ff + WORD_W'(1);
      end
      if (cmd.rsp_load) begin
         if (emit_ff) begin
            rsp_valid_in = 1'b1;
            birth_in     = ovf_ff ? '0 : count_ff[BIRTH_W-1:0];
            death_in     = ovf_ff ? '0 : p_ff;
            radds_in     = ovf_ff ? '0 : adds_ff;
            rovf_in      = ovf_ff;
         end
         if (!ovf_ff) begin
            count_in = count_ff + COUNT_W'(1);
            pos_in   = pos_ff + POS_W'(1);
         end
      end
      if (cmd.sw_start) begin
         sw_in = '0;
      end
      if (cmd.sw_next) begin
         sw_in = sw_ff + SLOT_W'(1);
      end
      if (cmd.sw_done) begin
         pos_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int w = 0; w < WORDS; w++) begin
            wc_ff[w] <= '0;
         end
         clr_ff        <= '0;
         count_ff      <= '0;
         pos_ff        <= '0;
         chunk_cols_ff <= CHUNK_COLUMNS_RESET;
         indep_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         wc_ff         <= wc_in;
         clr_ff        <= clr_in;
         count_ff      <= count_in;
         pos_ff        <= pos_in;
         chunk_cols_ff <= chunk_cols_in;
         indep_ff      <= indep_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      sw_ff    <= sw_in;
      p_ff     <= p_in;
      src_ff   <= src_in;
      adds_ff  <= adds_in;
      emit_ff  <= emit_in;
      ovf_ff   <= ovf_in;
      birth_ff <= birth_in;
      death_ff <= death_in;
      radds_ff <= radds_in;
      rovf_ff  <= rovf_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.wb) begin
         store_mem[{slot, word_ff}] <= wc_ff[word_ff];
      end
      if (cmd.st_rd) begin
         store_q_ff <= store_mem[{src_ff, word_ff}];
      end
   end

   always_ff @(posedge clock) begin
      if (ri_we) begin
         ri_mem[ri_waddr] <= ri_wdata;
      end
      if (ri_re) begin
         ri_q_ff <= ri_mem[ri_raddr];
      end
   end

   // A slot whose column claims no row (reduced to zero or already claimed
   // by an earlier chunk) is marked empty so the chunk sweep skips it.
   always_ff @(posedge clock) begin
      if (cmd.claim) begin
         piv_mem[slot] <= '{has: 1'b1, row: p_ff[ROW_W-1:0]};
      end else if (cmd.nopiv || cmd.skip) begin
         piv_mem[slot] <= '{has: 1'b0, row: '0};
      end
      if (cmd.sw_piv_rd) begin
         piv_q_ff <= piv_mem[sw_ff];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_column_number    = birth_ff;
   assign rsp_pivot_row        = death_ff;
   assign rsp_column_additions = radds_ff;
   assign rsp_overflow         = rovf_ff;

endmodule

// ===== sv/czr_ctrl.sv =====
// Controller state machine of the column reduction block. Sequences the
// datapath through commands and reads its status. Uses czr_pkg.
module czr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [czr_pkg::OP_W-1:0] req_operation,
   input  czr_pkg::status_type      status,
   output czr_pkg::cmd_type         cmd
);
   import czr_pkg::*;

   typedef enum logic [12:0] {
      S_CLEAR  = 13'b0000000000001,
      S_IDLE   = 13'b0000000000010,
      S_FIND   = 13'b0000000000100,
      S_LOOK   = 13'b0000000001000,
      S_RIW    = 13'b0000000010000,
      S_XRD    = 13'b0000000100000,
      S_XOR    = 13'b0000001000000,
      S_WB     = 13'b0000010000000,
      S_RESULT = 13'b0000100000000,
      S_POST   = 13'b0001000000000,
      S_SWPIV  = 13'b0010000000000,
      S_SWCHK  = 13'b0100000000000,
      S_SWWR   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic      ret_find_ff, ret_find_in;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in    = state_ff;
      ret_find_in = ret_find_ff;
      cmd         = '0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_row = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               case (op_type'(req_operation))
                  OP_ADD: cmd.add_entry = 1'b1;
                  OP_END: begin
                     if (status.full) begin
                        cmd.ovf_start = 1'b1;
                        state_in      = S_RESULT;
                     end else begin
                        cmd.col_start = 1'b1;
                        if (status.chunk_due) begin
                           cmd.sw_start = 1'b1;
                           ret_find_in  = 1'b1;
                           state_in     = S_SWPIV;
                        end else begin
                           state_in = S_FIND;
                        end
                     end
                  end
                  OP_NEW: begin
                     cmd.clr_start = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  default: ;
               endcase
            end
         end
         S_FIND: begin
            cmd.find_step = 1'b1;
            if (status.word_nz) begin
               state_in = S_LOOK;
            end else if (status.word_zero) begin
               cmd.nopiv = 1'b1;
               state_in  = S_WB;
            end
         end
         S_LOOK: begin
            cmd.ri_rd = 1'b1;
            state_in  = S_RIW;
         end
         S_RIW: begin
            if (status.ri_valid) begin
               cmd.add_start = 1'b1;
               state_in      = S_XRD;
            end else if (!status.indep && status.ri_claimed) begin
               cmd.skip = 1'b1;
               state_in = S_WB;
            end else begin
               cmd.claim = 1'b1;
               state_in  = S_WB;
            end
         end
         S_XRD: begin
            cmd.st_rd = 1'b1;
            state_in  = S_XOR;
         end
         S_XOR: begin
            cmd.st_xor = 1'b1;
            state_in   = status.word_last ? S_FIND : S_XRD;
         end
         S_WB: begin
            cmd.wb = 1'b1;
            if (status.word_last) begin
               state_in = S_RESULT;
            end
         end
         S_RESULT: begin
            if (!status.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_POST;
            end
         end
         S_POST: begin
            if (!status.ovf && status.chunk_due) begin
               cmd.sw_start = 1'b1;
               ret_find_in  = 1'b0;
               state_in     = S_SWPIV;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_SWPIV: begin
            cmd.sw_piv_rd = 1'b1;
            state_in      = S_SWCHK;
         end
         S_SWCHK: begin
            if (status.piv_has) begin
               cmd.sw_ri_rd = 1'b1;
               state_in     = S_SWWR;
            end else begin
               cmd.sw_next = 1'b1;
               if (status.sw_last) begin
                  cmd.sw_done = 1'b1;
                  state_in    = ret_find_ff ? S_FIND : S_IDLE;
               end else begin
                  state_in = S_SWPIV;
               end
            end
         end
         S_SWWR: begin
            cmd.sw_wr   = 1'b1;
            cmd.sw_next = 1'b1;
            if (status.sw_last) begin
               cmd.sw_done = 1'b1;
               state_in    = ret_find_ff ? S_FIND : S_IDLE;
            end else begin
               state_in = S_SWPIV;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_CLEAR;
         ret_find_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         ret_find_ff <= ret_find_in;
      end
   end

endmodule

// ===== sv/czr_checker.sv =====
// Port-level checker of the column reduction block and its bind.
// Depends on czr_pkg and the assertion macro header.
`include "chunked_z2_column_reduction_macros.svh"

module czr_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [czr_pkg::OP_W-1:0]            req_operation,
   input logic [czr_pkg::ROW_W-1:0]           req_row_index,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic [czr_pkg::BIRTH_W-1:0]         rsp_column_number,
   input logic signed [czr_pkg::DEATH_W-1:0]  rsp_pivot_row,
   input logic [czr_pkg::ADDS_W-1:0]          rsp_column_additions,
   input logic                                rsp_overflow,
   input logic                                csr_write_enable,
   input logic [czr_pkg::CSR_IDX_W-1:0]       csr_index,
   input logic [czr_pkg::CSR_W-1:0]           csr_write_data
);
   import czr_pkg::*;

   logic                                  ovf_fields_zero;
   logic [BIRTH_W+DEATH_W+ADDS_W:0]       rsp_payload;

   assign ovf_fields_zero = (rsp_column_number == '0) && (rsp_pivot_row == '0) &&
                            (rsp_column_additions == '0);
   assign rsp_payload     = {rsp_column_number, rsp_pivot_row, rsp_column_additions,
                             rsp_overflow};

   // No result is pending in the cycle after a reset edge.
   `CZR_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_valid, "result after reset")

   // The table clear after reset holds off input.
   `CZR_ASSERT(a_reset_quiet, $fell(reset) |-> req_stall, "busy after reset")

   // An overflow result carries zero in all other fields.
   `CZR_ASSERT(a_ovf_zero, (rsp_valid && rsp_overflow) |-> ovf_fields_zero, "overflow fields")

   // A pivot row is either a row or minus one.
   `CZR_ASSERT(a_death_range, rsp_valid |-> (!rsp_pivot_row[DEATH_W-1] || rsp_pivot_row == '1), "pivot range")

   // A stalled result transfer holds its payload.
   `CZR_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)), "result changed")

endmodule

bind chunked_z2_column_reduction czr_checker u_czr_checker (.*);
